[rtl/core/hpq_pkg.sv]
// hpq_pkg: shared types and codes for the binary max-heap priority queue
// request and result item structs, operation and status codes
// no dependencies
package hpq_pkg;

    typedef logic signed [31:0] key_t;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam key_t NONE_KEY = -32'sd1;

    localparam int COUNT_FIELD_W = 11;

    typedef struct packed {
        logic op;
        key_t key_value;
    } in_item_t;

    typedef struct packed {
        key_t                     extracted_key;
        key_t                     top_key;
        logic [COUNT_FIELD_W-1:0] entry_count;
        status_t                  status;
    } out_item_t;

endpackage

[rtl/core/hpq_ram.sv]
// hpq_ram: heap key store, one write port and two registered read ports
// depends on hpq_pkg for the key type
module hpq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  hpq_pkg::key_t wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output hpq_pkg::key_t rdata_a,
    output hpq_pkg::key_t rdata_b
);
    import hpq_pkg::*;

    key_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/core/hpq_engine.sv]
// hpq_engine: sequencer for insert / sift-up and extract / sift-down
// drives the heap store read and write ports; depends on hpq_pkg
module hpq_engine #(
    parameter int CAPACITY = 1024,
    parameter int AW       = 10,
    parameter int CW       = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hpq_pkg::in_item_t  req,
    output logic               res_valid,
    input  logic               res_ready,
    output hpq_pkg::out_item_t res,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output hpq_pkg::key_t      wdata,
    output logic [AW-1:0]      raddr_a,
    output logic [AW-1:0]      raddr_b,
    input  hpq_pkg::key_t      rdata_a,
    input  hpq_pkg::key_t      rdata_b
);
    import hpq_pkg::*;

    localparam int XW = CW + 1;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_RD  = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_DN_KEY = 7'b0001000,
        S_DN_RD  = 7'b0010000,
        S_DN_CMP = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    key_t          key_reg, key_next;
    key_t          root_reg;
    key_t          extracted_reg, extracted_next;
    status_t       status_reg, status_next;

    logic [AW-1:0] parent_idx;
    logic [XW-1:0] left_idx, right_idx, count_x;
    logic [CW-1:0] last_idx;
    logic          left_ok, right_ok, left_gt, right_gt;
    key_t          best_val;
    logic [CW+COUNT_FIELD_W-1:0] count_wide;

    // index arithmetic
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = XW'({pos_reg, 1'b0}) + XW'(1);
    assign right_idx  = XW'({pos_reg, 1'b0}) + XW'(2);
    assign count_x    = XW'(count_reg);
    assign last_idx   = count_reg - CW'(1);

    // child selection, left wins a tie, moves only on strict compare
    assign left_ok  = left_idx < count_x;
    assign right_ok = right_idx < count_x;
    assign left_gt  = left_ok && (rdata_a > key_reg);
    assign best_val = left_gt ? rdata_a : key_reg;
    assign right_gt = right_ok && (rdata_b > best_val);

    // read addresses
    always_comb
    begin
        raddr_a = last_idx[AW-1:0];
        raddr_b = right_idx[AW-1:0];
        case (state_reg)
            S_UP_RD: raddr_a = parent_idx;
            S_DN_RD: raddr_a = left_idx[AW-1:0];
            default: raddr_a = last_idx[AW-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        extracted_next = extracted_reg;
        status_next    = status_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    extracted_next = NONE_KEY;
                    status_next    = ST_OK;
                    key_next       = req.key_value;
                    if (req.op == OP_INSERT)
                    begin
                        if (count_reg >= CAP_COUNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // last entry is being read this cycle
                        extracted_next = root_reg;
                        count_next     = last_idx;
                        state_next     = S_DN_KEY;
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (rdata_a < key_reg)
                begin
                    // parent drops into the hole
                    wdata      = rdata_a;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_KEY:
            begin
                key_next = rdata_a;
                pos_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (left_gt || right_gt)
                begin
                    // larger child rises into the hole
                    wdata      = right_gt ? rdata_b : rdata_a;
                    pos_next   = right_gt ? right_idx[AW-1:0] : left_idx[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers, root copy mirrors every write to entry zero
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        extracted_reg <= extracted_next;
        status_reg    <= status_next;
        if (we && waddr == '0)
        begin
            root_reg <= wdata;
        end
    end

    // result
    assign count_wide        = (CW + COUNT_FIELD_W)'(count_reg);
    assign req_ready         = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.extracted_key = extracted_reg;
    assign res.top_key       = (count_reg != '0) ? root_reg : NONE_KEY;
    assign res.entry_count   = count_wide[COUNT_FIELD_W-1:0];
    assign res.status        = status_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("held count above capacity");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (XW'(waddr) < count_x))
        else $error("heap write outside held entries");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg == S_UP_CMP)) |-> (waddr != parent_idx))
        else $error("sift-up write collides with parent read");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(count_reg)))
        else $error("result dropped before handoff");

endmodule

[rtl/core/binary_max_heap_priority_queue.sv]
// Binary max-heap priority queue, top level. Each request inserts one signed
// 32-bit key or extracts the maximum; each gives exactly one result holding the
// extracted key, the new maximum, the held count and a status. One request is
// worked at a time. An insert reads and compares once per level the key climbs;
// an extract moves the last entry to the root and reads and compares once per
// level it sinks. Each level's compare waits on the heap store's registered
// read. No clearing pass follows reset; entries are only read once written.
// A finished result waits in the output register while the next request runs.
// depends on hpq_pkg, hpq_ram, hpq_engine
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hpq_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hpq_pkg::out_item_t out_data
);
    import hpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          res_valid, res_ready;
    out_item_t     res;
    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    key_t          wdata, rdata_a, rdata_b;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    hpq_ram #(
        .DEPTH(CAPACITY),
        .AW   (AW)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    hpq_engine #(
        .CAPACITY(CAPACITY),
        .AW      (AW),
        .CW      (CW)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(in_valid),
        .req_ready(in_ready),
        .req      (in_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .we       (we),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr_a  (raddr_a),
        .raddr_b  (raddr_b),
        .rdata_a  (rdata_a),
        .rdata_b  (rdata_b)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[verif/tb_binary_max_heap_priority_queue.sv]
// tb_binary_max_heap_priority_queue: self-checking bench for the max-heap priority queue
// directed table then random insert/extract traffic, checked against a heap predictor
// depends on hpq_pkg and binary_max_heap_priority_queue
`timescale 1ns / 100ps

module tb_binary_max_heap_priority_queue;

    import hpq_pkg::*;

    localparam int   CAPACITY = 1024;
    localparam key_t KEY_MAX  = 32'sh7fffffff;
    localparam key_t KEY_MIN  = 32'sh80000000;
    localparam int   NUM_DIRECTED = 26;
    localparam int   MIX_REQUESTS = 175;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic      op;
        key_t      key;
        bit        typed;
        out_item_t want;
    } directed_row_t;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{OP_EXTRACT, 32'sd0,         1'b1, '{NONE_KEY, NONE_KEY, 11'd0, ST_EMPTY}},
        '{OP_INSERT,  KEY_MAX,        1'b1, '{NONE_KEY, KEY_MAX, 11'd1, ST_OK}},
        '{OP_INSERT,  KEY_MIN,        1'b1, '{NONE_KEY, KEY_MAX, 11'd2, ST_OK}},
        '{OP_INSERT,  -32'sd1,        1'b0, '0},
        '{OP_INSERT,  32'sd0,         1'b0, '0},
        '{OP_INSERT,  KEY_MAX,        1'b0, '0},
        '{OP_INSERT,  32'sd5,         1'b0, '0},
        '{OP_INSERT,  32'sd5,         1'b0, '0},
        '{OP_INSERT,  32'sh55555555,  1'b0, '0},
        '{OP_INSERT,  32'shaaaaaaaa,  1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b1, '{KEY_MIN, NONE_KEY, 11'd0, ST_OK}},
        '{OP_EXTRACT, -32'sd1,        1'b1, '{NONE_KEY, NONE_KEY, 11'd0, ST_EMPTY}},
        '{OP_INSERT,  32'sd10,        1'b0, '0},
        '{OP_INSERT,  32'sd7,         1'b0, '0},
        '{OP_INSERT,  32'sd7,         1'b0, '0},
        '{OP_INSERT,  32'sd1,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0},
        '{OP_EXTRACT, 32'sd0,         1'b0, '0}
    };

    // heap predictor state
    key_t heap_keys [CAPACITY];
    int   held_keys = 0;

    out_item_t expected_results [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int requests_sent  = 0;
    int drops_on_full  = 0;
    int empty_extracts = 0;
    int peak_held      = 0;
    int mismatches     = 0;

    binary_max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // apply one request to the predictor heap and return its result
    function automatic out_item_t heap_apply(input logic op, input key_t key);
        out_item_t res;
        int        pos;
        int        best;
        int        child;
        key_t      tmp;
        res.extracted_key = NONE_KEY;
        res.status        = ST_OK;
        if (op == OP_INSERT)
        begin
            if (held_keys >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                // append and sift up while the parent is strictly smaller
                heap_keys[held_keys] = key;
                pos = held_keys;
                held_keys++;
                while (pos > 0 && heap_keys[(pos - 1) / 2] < heap_keys[pos])
                begin
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[(pos - 1) / 2];
                    heap_keys[(pos - 1) / 2] = tmp;
                    pos = (pos - 1) / 2;
                end
            end
        end
        else if (held_keys == 0)
            res.status = ST_EMPTY;
        else
        begin
            // take the root, move the last entry up and sift it down
            res.extracted_key = heap_keys[0];
            held_keys--;
            heap_keys[0] = heap_keys[held_keys];
            pos = 0;
            while (1)
            begin
                child = 2 * pos + 1;
                best  = pos;
                // left child wins a tie since the right one must be strictly larger
                if (child < held_keys && heap_keys[best] < heap_keys[child])
                    best = child;
                if (child + 1 < held_keys && heap_keys[best] < heap_keys[child + 1])
                    best = child + 1;
                if (best == pos)
                    break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[best];
                heap_keys[best] = tmp;
                pos = best;
            end
        end
        res.top_key     = (held_keys > 0) ? heap_keys[0] : NONE_KEY;
        res.entry_count = COUNT_FIELD_W'(held_keys);
        return res;
    endfunction

    // mostly random keys, with extremes and a narrow band that forces ties
    function automatic key_t pick_key();
        case ($urandom_range(9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3:    return key_t'($urandom_range(8)) - 32'sd4;
            default: return key_t'($urandom);
        endcase
    endfunction

    // drive one request, hold it until accepted, then record its expected result
    task automatic send_request(input logic op, input key_t key, input bit typed,
                                input out_item_t want);
        out_item_t predicted;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, key_value: key};
        do @(posedge clk); while (!in_ready);
        predicted = heap_apply(op, key);
        expected_results.push_back(typed ? want : predicted);
        requests_sent++;
        if (predicted.status == ST_FULL)
            drops_on_full++;
        if (predicted.status == ST_EMPTY)
            empty_extracts++;
        if (held_keys > peak_held)
            peak_held = held_keys;
    endtask

    // hold off new requests until every outstanding result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // random insert/extract mix; the insert share shifts every 30 requests
    task automatic run_mix(input int count);
        int   insert_pct;
        logic op;
        insert_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
                insert_pct = 25 * $urandom_range(3, 1);
            op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
            send_request(op, pick_key(), 1'b0, '0);
        end
    endtask

    // result checker with random backpressure
    initial
    begin : result_checker
        out_item_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing outstanding: extracted_key %0d top_key %0d",
                           out_data.extracted_key, out_data.top_key);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.extracted_key !== want.extracted_key)
                    begin
                        $error("extracted_key: expected %0d, got %0d",
                               want.extracted_key, out_data.extracted_key);
                        mismatches++;
                    end
                    if (out_data.top_key !== want.top_key)
                    begin
                        $error("top_key: expected %0d, got %0d", want.top_key, out_data.top_key);
                        mismatches++;
                    end
                    if (out_data.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, out_data.entry_count);
                        mismatches++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, idling on both sides, receiver more than sender
        tx_idle_pct = 26;
        rx_idle_pct = 61;
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // random mix, sender idles less than receiver
        run_mix(MIX_REQUESTS);
        wait_drained();

        // random mix, sender idles more than receiver
        tx_idle_pct = 61;
        rx_idle_pct = 26;
        run_mix(MIX_REQUESTS);
        wait_drained();

        // no idling, requests back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_mix(MIX_REQUESTS);
        wait_drained();
        repeat (40) @(posedge clk);

        $display("ran %0d requests, peak heap size %0d of %0d", requests_sent, peak_held,
                 CAPACITY);
        $display("%0d inserts dropped on a full heap, %0d extracts from an empty heap",
                 drops_on_full, empty_extracts);
        if (mismatches == 0)
            $display("tb_binary_max_heap_priority_queue: PASS");
        else
            $display("tb_binary_max_heap_priority_queue: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb_binary_max_heap_priority_queue: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hpq_pkg.sv
rtl/core/hpq_ram.sv
rtl/core/hpq_engine.sv
rtl/core/binary_max_heap_priority_queue.sv
verif/tb_binary_max_heap_priority_queue.sv
